// File: src/lwbc_pkg.sv
`timescale 1ns / 1ps
package lwbc_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    localparam logic [2:0] K_READ  = 3'd0;
    localparam logic [2:0] K_WB    = 3'd1;
    localparam logic [2:0] K_FETCH = 3'd2;
    localparam logic [2:0] K_ACK   = 3'd3;
    localparam logic [2:0] K_DONE  = 3'd4;
    localparam logic [2:0] K_REJ   = 3'd5;

    localparam int BLK_W = 16;
    localparam int WORD_W = 64;

    typedef enum logic [3:0] {
        C_NONE,
        C_LATCH,
        C_FILL,
        C_RD_HIT,
        C_RD_VICTIM,
        C_CLAIM_RD,
        C_CLAIM_WR,
        C_WR_HIT,
        C_SCAN_CLR,
        C_SCAN_RD,
        C_SCAN_INC
    } op_cmd_t;

    typedef enum logic [1:0] {
        D_ZERO,
        D_MEM,
        D_IN
    } dsel_t;

    typedef enum logic [1:0] {
        B_ZERO,
        B_MEM,
        B_IN
    } bsel_t;

    typedef struct packed {
        op_cmd_t    op;
        logic       emit;
        logic [2:0] kind;
        logic       hit;
        logic       last;
        dsel_t      dsel;
        bsel_t      bsel;
    } cmd_t;

    typedef struct packed {
        logic       pending;
        logic [1:0] opcode;
        logic       pend_match;
        logic       hit;
        logic       full;
        logic       victim_dirty;
        logic       scan_done;
        logic       scan_dirty;
        logic       out_free;
    } status_t;

endpackage

// File: src/lwbc_ctrl.sv
`timescale 1ns / 1ps
module lwbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lwbc_pkg::status_t st,
    output lwbc_pkg::cmd_t    cmd
);
    import lwbc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_RDHIT  = 7'b0000100,
        S_VICWB  = 7'b0001000,
        S_CLAIM  = 7'b0010000,
        S_FSCAN  = 7'b0100000,
        S_FWB    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '{op: C_NONE, emit: 1'b0, kind: K_REJ, hit: 1'b0, last: 1'b1,
                dsel: D_ZERO, bsel: B_IN};
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = C_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.pending || st.opcode == OP_FILL) begin
                    if (st.out_free) begin
                        cmd.emit = 1'b1;
                        if (st.pending && st.opcode == OP_FILL && st.pend_match) begin
                            cmd.op = C_FILL;
                            cmd.kind = K_READ;
                            cmd.dsel = D_IN;
                        end
                        state_next = S_IDLE;
                    end
                end else if (st.opcode == OP_FLUSH) begin
                    cmd.op = C_SCAN_CLR;
                    state_next = S_FSCAN;
                end else if (st.hit && st.opcode == OP_READ) begin
                    cmd.op = C_RD_HIT;
                    state_next = S_RDHIT;
                end else if (st.hit) begin
                    if (st.out_free) begin
                        cmd.op = C_WR_HIT;
                        cmd.emit = 1'b1;
                        cmd.kind = K_ACK;
                        cmd.hit = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (st.full && st.victim_dirty) begin
                    cmd.op = C_RD_VICTIM;
                    state_next = S_VICWB;
                end else begin
                    state_next = S_CLAIM;
                end
            end
            S_RDHIT: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_READ;
                    cmd.hit = 1'b1;
                    cmd.dsel = D_MEM;
                    state_next = S_IDLE;
                end
            end
            S_VICWB: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_WB;
                    cmd.last = 1'b0;
                    cmd.dsel = D_MEM;
                    cmd.bsel = B_MEM;
                    state_next = S_CLAIM;
                end
            end
            S_CLAIM: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    if (st.opcode == OP_READ) begin
                        cmd.op = C_CLAIM_RD;
                        cmd.kind = K_FETCH;
                    end else begin
                        cmd.op = C_CLAIM_WR;
                        cmd.kind = K_ACK;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (st.scan_done) begin
                    if (st.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.kind = K_DONE;
                        cmd.bsel = B_ZERO;
                        state_next = S_IDLE;
                    end
                end else if (st.scan_dirty) begin
                    cmd.op = C_SCAN_RD;
                    state_next = S_FWB;
                end else begin
                    cmd.op = C_SCAN_INC;
                end
            end
            S_FWB: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_WB;
                    cmd.last = 1'b0;
                    cmd.dsel = D_MEM;
                    cmd.bsel = B_MEM;
                    state_next = S_FSCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// File: src/lwbc_datapath.sv
`timescale 1ns / 1ps
module lwbc_datapath #(
    parameter int ENTRIES = 16,
    parameter int BLOCK_BYTES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [1:0]                 in_opcode,
    input  logic [lwbc_pkg::BLK_W-1:0] in_block,
    input  logic [lwbc_pkg::WORD_W-1:0] in_data,
    input  lwbc_pkg::cmd_t             cmd,
    output lwbc_pkg::status_t          st,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [2:0]                 out_kind,
    output logic [lwbc_pkg::BLK_W-1:0] out_block,
    output logic [lwbc_pkg::WORD_W-1:0] out_data,
    output logic                       out_hit,
    output logic                       out_last
);
    import lwbc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = 8 * BLOCK_BYTES;
    localparam int MW = BLK_W + DW;

    logic [BLK_W-1:0] tag_reg [ENTRIES];
    logic [IW-1:0]    rank_reg [ENTRIES];
    logic [ENTRIES-1:0] dirty_reg;
    logic [CW-1:0]    occ_reg;
    logic             pend_reg;
    logic [IW-1:0]    pend_slot_reg;
    logic [BLK_W-1:0] pend_blk_reg;
    logic [CW-1:0]    scan_reg;
    logic [1:0]       op_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [DW-1:0]    data_reg;
    logic [MW-1:0]    mem [ENTRIES];
    logic [MW-1:0]    rd_reg;

    logic [ENTRIES-1:0] valid, hit_vec, vic_vec, scan_vec;
    logic [IW-1:0] hit_idx, vic_idx, scan_idx, claim_idx, wr_idx;
    logic full;
    logic mem_we;

    always_comb begin
        hit_idx = '0;
        vic_idx = '0;
        scan_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            valid[i] = CW'(i) < occ_reg;
            hit_vec[i] = valid[i] && tag_reg[i] == blk_reg;
            vic_vec[i] = rank_reg[i] == IW'(ENTRIES - 1);
            scan_vec[i] = valid[i] && CW'(rank_reg[i]) == scan_reg;
            if (hit_vec[i]) hit_idx = hit_idx | IW'(i);
            if (vic_vec[i]) vic_idx = vic_idx | IW'(i);
            if (scan_vec[i]) scan_idx = scan_idx | IW'(i);
        end
    end

    assign full = occ_reg == CW'(ENTRIES);
    assign claim_idx = full ? vic_idx : occ_reg[IW-1:0];

    always_comb begin
        st.pending = pend_reg;
        st.opcode = op_reg;
        st.pend_match = blk_reg == pend_blk_reg;
        st.hit = |hit_vec;
        st.full = full;
        st.victim_dirty = |(vic_vec & dirty_reg);
        st.scan_done = scan_reg == occ_reg;
        st.scan_dirty = |(scan_vec & dirty_reg);
        st.out_free = !m_tvalid || m_tready;
    end

    always_comb begin
        mem_we = 1'b0;
        wr_idx = hit_idx;
        case (cmd.op)
            C_FILL: begin
                mem_we = 1'b1;
                wr_idx = pend_slot_reg;
            end
            C_WR_HIT: mem_we = 1'b1;
            C_CLAIM_WR: begin
                mem_we = 1'b1;
                wr_idx = claim_idx;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx] <= {blk_reg, data_reg};
        end
        case (cmd.op)
            C_RD_HIT: rd_reg <= mem[hit_idx];
            C_RD_VICTIM: rd_reg <= mem[vic_idx];
            C_SCAN_RD: rd_reg <= mem[scan_idx];
            default: rd_reg <= rd_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == C_LATCH) begin
            op_reg <= in_opcode;
            blk_reg <= in_block;
            data_reg <= in_data[DW-1:0];
        end
        if (cmd.op == C_CLAIM_RD || cmd.op == C_CLAIM_WR) begin
            tag_reg[claim_idx] <= blk_reg;
        end
        if (cmd.emit) begin
            out_kind <= cmd.kind;
            out_hit <= cmd.hit;
            out_last <= cmd.last;
            case (cmd.dsel)
                D_MEM: out_data <= WORD_W'(rd_reg[DW-1:0]);
                D_IN: out_data <= WORD_W'(data_reg);
                default: out_data <= '0;
            endcase
            case (cmd.bsel)
                B_MEM: out_block <= rd_reg[MW-1:DW];
                B_IN: out_block <= blk_reg;
                default: out_block <= '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
            dirty_reg <= '0;
            occ_reg <= '0;
            pend_reg <= 1'b0;
            pend_slot_reg <= '0;
            pend_blk_reg <= '0;
            scan_reg <= '0;
            m_tvalid <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            case (cmd.op)
                C_FILL: begin
                    dirty_reg[pend_slot_reg] <= 1'b0;
                    pend_reg <= 1'b0;
                end
                C_RD_HIT, C_WR_HIT: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (IW'(i) == hit_idx) begin
                            rank_reg[i] <= '0;
                        end else if (valid[i] && rank_reg[i] < rank_reg[hit_idx]) begin
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                        end
                    end
                    if (cmd.op == C_WR_HIT) dirty_reg[hit_idx] <= 1'b1;
                end
                C_RD_VICTIM: dirty_reg[vic_idx] <= 1'b0;
                C_CLAIM_RD, C_CLAIM_WR: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (IW'(i) == claim_idx) begin
                            rank_reg[i] <= '0;
                        end else if (valid[i]) begin
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                        end
                    end
                    if (!full) occ_reg <= occ_reg + 1'b1;
                    dirty_reg[claim_idx] <= (cmd.op == C_CLAIM_WR);
                    if (cmd.op == C_CLAIM_RD) begin
                        pend_reg <= 1'b1;
                        pend_slot_reg <= claim_idx;
                        pend_blk_reg <= blk_reg;
                    end
                end
                C_SCAN_CLR: scan_reg <= '0;
                C_SCAN_RD: begin
                    dirty_reg[scan_idx] <= 1'b0;
                    scan_reg <= scan_reg + 1'b1;
                end
                C_SCAN_INC: scan_reg <= scan_reg + 1'b1;
                default: scan_reg <= scan_reg;
            endcase
        end
    end
endmodule

// File: src/lru_writeback_block_cache.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                               tuser              tlast
// s_       in   [15:0] block_number, [79:16] data   [1:0] opcode       -
// m_       out  [15:0] target_block, [79:16] data   [2:0] kind, [3] hit  last
//
// One request at a time. A miss on a full cache writes back a dirty victim
// first; flush scans every occupied entry and writes back each dirty one. Tag
// compare, rank update and one data-memory port set the order of these steps.
// Reset (synchronous, aresetn low) empties the cache and clears dirty marks.
// A stalled m_ beat holds; the next request is taken while it waits.
module lru_writeback_block_cache #(
    parameter int ENTRIES = 16,
    parameter int BLOCK_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // block_number, request_data
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // target_block, result_data
    output logic [3:0]  m_tuser,   // kind, hit
    output logic        m_tlast
);
    import lwbc_pkg::*;

    cmd_t cmd;
    status_t st;
    logic [2:0] kind;
    logic [BLK_W-1:0] blk;
    logic [WORD_W-1:0] data;
    logic hit;

    lwbc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .st(st), .cmd(cmd)
    );

    lwbc_datapath #(.ENTRIES(ENTRIES), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_opcode(s_tuser), .in_block(s_tdata[15:0]), .in_data(s_tdata[79:16]),
        .cmd(cmd), .st(st), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .out_kind(kind), .out_block(blk), .out_data(data), .out_hit(hit),
        .out_last(m_tlast)
    );

    assign m_tdata = {data, blk};
    assign m_tuser = {hit, kind};
endmodule
